// ----- design/skac_pkg.sv -----
// Shared types, constants and the power-root table for the soft-knee compressor
package skac_pkg;

    localparam int SAMPLE_BITS = 24;

    // Shared unit widths
    localparam int MUL_W   = 32;
    localparam int NUM_W   = 47;
    localparam int DEN_W   = 30;
    localparam int QUOT_W  = 18;
    localparam int LVL_W   = 18;
    localparam int GLOG_W  = 21;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Level of a zero sample, Q8.8 dB
    localparam logic signed [17:0] LEVEL_ZERO     = -18'sd40960;
    // 20*log10(2) in Q.16 applied to the log2 level
    localparam logic [31:0]        LOG_TO_DB      = 32'd394566;
    // dB to log2 attenuation
    localparam logic [31:0]        DB_TO_LOG      = 32'd10885;
    localparam logic [31:0]        RATIO_ONE      = 32'd65535;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_KNEE      = 3'd1,
        REG_INV_RATIO = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4,
        REG_MAKEUP    = 3'd5
    } skac_reg_idx_t;

    typedef struct packed {
        logic signed [14:0] threshold_level;
        logic [13:0]        knee_width;
        logic [15:0]        inverse_ratio;
        logic [15:0]        attack_coefficient;
        logic [15:0]        release_coefficient;
        logic [15:0]        makeup_gain;
    } skac_cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } skac_div_req_t;

    typedef logic [31:0] skac_roots_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > x)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Roots 2^(-2^-(k+1)) in Q0.32, each the square root of the one before
    function automatic skac_roots_t build_roots();
        skac_roots_t t;
        logic [63:0] v;
        v = isqrt64(64'd1 << 63);
        t[0] = v[31:0];
        for (int k = 1; k < 16; k++)
        begin
            v = isqrt64({t[k-1], 32'd0});
            t[k] = v[31:0];
        end
        return t;
    endfunction

    localparam skac_roots_t POW_ROOTS = build_roots();

endpackage

// ----- design/skac_cfg_regs.sv -----
// Configuration register file of the compressor
module skac_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [skac_pkg::IDX_W-1:0] cfg_addr,
    input  logic [skac_pkg::CFG_W-1:0] cfg_wdata,
    output skac_pkg::skac_cfg_t       cfg
);
    import skac_pkg::*;

    skac_cfg_t cfg_reg;
    skac_cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (skac_reg_idx_t'(cfg_addr))
                REG_THRESHOLD: cfg_next.threshold_level     = cfg_wdata[14:0];
                REG_KNEE:      cfg_next.knee_width          = cfg_wdata[13:0];
                REG_INV_RATIO: cfg_next.inverse_ratio       = cfg_wdata;
                REG_ATTACK:    cfg_next.attack_coefficient  = cfg_wdata;
                REG_RELEASE:   cfg_next.release_coefficient = cfg_wdata;
                REG_MAKEUP:    cfg_next.makeup_gain         = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level     <= '0;
            cfg_reg.knee_width          <= '0;
            cfg_reg.inverse_ratio       <= 16'hFFFF;
            cfg_reg.attack_coefficient  <= '0;
            cfg_reg.release_coefficient <= '0;
            cfg_reg.makeup_gain         <= 16'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/skac_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the static gain curve
module skac_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  skac_pkg::skac_div_req_t     req,
    output logic                        done,
    output logic [skac_pkg::QUOT_W-1:0] quot
);
    import skac_pkg::*;

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [QUOT_W-1:0] dq_reg;
    logic [QUOT_W-1:0] dq_next;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // Shift in one numerator bit and try the subtract
    always_comb
    begin
        trial    = {rem_reg, dq_reg[QUOT_W-1]};
        fits     = (trial >= {1'b0, req.den});
        rem_next = fits ? DEN_W'(trial - {1'b0, req.den}) : trial[DEN_W-1:0];
        dq_next  = {dq_reg[QUOT_W-2:0], fits};
    end

    // Control: load, iterate, flag the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient fits QUOT_W bits, so the top part starts below den
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DEN_W'(req.num[NUM_W-1:QUOT_W]);
            dq_reg  <= req.num[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

// ----- design/skac_engine.sv -----
// Sequencer around one shared 32x32 multiplier: level, curve, detector, gain
module skac_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  skac_pkg::skac_cfg_t              cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [skac_pkg::SAMPLE_BITS-1:0] sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [skac_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic [15:0]                      gain_reduction,
    output skac_pkg::skac_div_req_t          div_req,
    input  logic                             div_done,
    input  logic [skac_pkg::QUOT_W-1:0]      div_quot
);
    import skac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LOG, S_LVL, S_CURVE, S_KNEE, S_DIVW, S_REL1,
        S_REL2, S_ATK1, S_ATK2, S_GLOG, S_POW, S_GSH, S_KMUL, S_OMUL
    } state_t;

    localparam logic [20:0] FULL_LOG = 21'((SAMPLE_BITS - 1) << 16);
    localparam logic [38:0] HALF     = 39'd1 << (SAMPLE_BITS - 1);

    state_t                 state_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [31:0]            n_reg;
    logic [4:0]             p_reg;
    logic [15:0]            frac_reg;
    logic [3:0]             cnt_reg;
    logic signed [17:0]     xg_reg;
    logic [15:0]            e_reg;
    logic [LVL_W-1:0]       xl_reg;
    logic                   scale_reg;
    logic [34:0]            acc_reg;
    logic [LVL_W-1:0]       rel_lvl_reg;
    logic [LVL_W-1:0]       atk_lvl_reg;
    logic [GLOG_W-1:0]      glog_reg;
    logic [31:0]            g_reg;
    logic [31:0]            k_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [15:0]            gain_red_reg;
    skac_div_req_t          div_req_reg;

    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [32:0]            sq;
    logic [20:0]            diff;
    logic [40:0]            lvl_sum;
    logic [15:0]            c_val;
    logic signed [17:0]     d_val;
    logic signed [18:0]     e_val;
    logic                   d_pos;
    logic                   hard;
    logic                   in_knee;
    logic                   above;
    logic [34:0]            sc_num;
    logic [19:0]            sc_s;
    logic [16:0]            sc_t;
    logic [18:0]            sc_q;
    logic [35:0]            sm_sum;
    logic [18:0]            sm_val;
    logic [32:0]            glog_sum;
    logic [63:0]            pow_sum;
    logic [47:0]            k_sum;
    logic [63:0]            o_sum;
    logic [38:0]            o_val;
    logic [38:0]            o_sat;
    logic [18:0]            gr_sum;

    // Input magnitude
    assign in_mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1) : sample;

    // Curve decisions
    always_comb
    begin
        c_val   = 16'hFFFF - cfg.inverse_ratio;
        d_val   = xg_reg - {{3{cfg.threshold_level[14]}}, cfg.threshold_level};
        e_val   = {d_val, 1'b0} + $signed({5'd0, cfg.knee_width});
        d_pos   = !d_val[17] && (d_val != 18'sd0);
        hard    = (cfg.knee_width == 14'd0);
        in_knee = !hard && !e_val[18] && (e_val <= $signed({4'd0, cfg.knee_width, 1'b0}));
        above   = hard ? d_pos : (!e_val[18] && !in_knee);
    end

    // Divide 8*c*d by 65535: fold the 16-bit halves twice, then one correction
    always_comb
    begin
        sc_num = {acc_reg[31:0], 3'b000};
        sc_s   = 20'(sc_num[34:16]) + 20'(sc_num[15:0]);
        sc_t   = 17'(sc_s[19:16]) + 17'(sc_s[15:0]);
        sc_q   = 19'(sc_num[34:16]) + 19'(sc_s[19:16])
                 + 19'(sc_t >= 17'(RATIO_ONE));
    end

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_LOG:
            begin
                mul_a = n_reg;
                mul_b = n_reg;
            end
            S_LVL:
            begin
                mul_a = 32'(diff);
                mul_b = LOG_TO_DB;
            end
            S_CURVE:
            begin
                mul_a = 32'(c_val);
                mul_b = in_knee ? 32'(e_val[15:0]) : 32'(d_val[15:0]);
            end
            S_KNEE:
            begin
                mul_a = acc_reg[31:0];
                mul_b = 32'(e_reg);
            end
            S_REL1:
            begin
                mul_a = 32'(cfg.release_coefficient);
                mul_b = 32'(rel_lvl_reg);
            end
            S_REL2:
            begin
                mul_a = 32'(17'h10000 - {1'b0, cfg.release_coefficient});
                mul_b = 32'(xl_reg);
            end
            S_ATK1:
            begin
                mul_a = 32'(cfg.attack_coefficient);
                mul_b = 32'(atk_lvl_reg);
            end
            S_ATK2:
            begin
                mul_a = 32'(17'h10000 - {1'b0, cfg.attack_coefficient});
                mul_b = 32'(rel_lvl_reg);
            end
            S_GLOG:
            begin
                mul_a = 32'(atk_lvl_reg);
                mul_b = DB_TO_LOG;
            end
            S_POW:
            begin
                mul_a = g_reg;
                mul_b = POW_ROOTS[cnt_reg];
            end
            S_KMUL:
            begin
                mul_a = g_reg;
                mul_b = 32'(cfg.makeup_gain);
            end
            S_OMUL:
            begin
                mul_a = 32'(mag_reg);
                mul_b = k_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Post-multiply arithmetic for each step
    always_comb
    begin
        sq       = mul_p[63:31];
        diff     = FULL_LOG - {p_reg, frac_reg};
        lvl_sum  = mul_p[40:0] + 41'(1 << 23);
        sm_sum   = 36'(acc_reg) + 36'(mul_p[34:0]) + 36'd32768;
        sm_val   = sm_sum[34:16];
        glog_sum = 33'(mul_p[31:0]) + 33'd1024;
        pow_sum  = mul_p + 64'(32'h8000_0000);
        k_sum    = mul_p[47:0] + 48'd32768;
        o_sum    = mul_p + 64'(1 << 24);
        o_val    = o_sum[63:25];
        if (neg_reg)
        begin
            o_sat = (o_val > HALF) ? HALF : o_val;
        end
        else
        begin
            o_sat = (o_val > HALF - 39'd1) ? HALF - 39'd1 : o_val;
        end
        gr_sum   = {1'b0, atk_lvl_reg} + 19'd4;
    end

    // Sequencer, detector state and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rel_lvl_reg   <= '0;
            atk_lvl_reg   <= '0;
            out_valid_reg <= 1'b0;
            div_req_reg   <= '0;
        end
        else
        begin
            div_req_reg.start <= (state_reg == S_KNEE);
            if ((state_reg == S_OMUL) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        neg_reg <= sample[SAMPLE_BITS-1];
                        mag_reg <= in_mag;
                        n_reg   <= 32'(in_mag);
                        p_reg   <= 5'd31;
                        if (in_mag == '0)
                        begin
                            xg_reg    <= LEVEL_ZERO;
                            state_reg <= S_CURVE;
                        end
                        else
                        begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                // Left-justify the magnitude, a byte or a bit a cycle
                S_NORM:
                begin
                    if (n_reg[31])
                    begin
                        cnt_reg   <= 4'd15;
                        frac_reg  <= '0;
                        state_reg <= S_LOG;
                    end
                    else if (n_reg[31:24] == 8'd0)
                    begin
                        n_reg <= n_reg << 8;
                        p_reg <= p_reg - 5'd8;
                    end
                    else
                    begin
                        n_reg <= n_reg << 1;
                        p_reg <= p_reg - 5'd1;
                    end
                end
                // One fraction bit of log2 per squaring
                S_LOG:
                begin
                    frac_reg[cnt_reg] <= sq[32];
                    n_reg             <= sq[32] ? sq[32:1] : sq[31:0];
                    cnt_reg           <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= S_LVL;
                    end
                end
                S_LVL:
                begin
                    xg_reg    <= -$signed({1'b0, lvl_sum[40:24]});
                    state_reg <= S_CURVE;
                end
                // Pick the curve region; keep c*d for the hard slope
                S_CURVE:
                begin
                    e_reg   <= e_val[15:0];
                    acc_reg <= 35'(mul_p[31:0]);
                    if (in_knee)
                    begin
                        scale_reg <= 1'b0;
                        state_reg <= S_KNEE;
                    end
                    else
                    begin
                        xl_reg    <= '0;
                        scale_reg <= above;
                        state_reg <= S_REL1;
                    end
                end
                // Start the knee divide
                S_KNEE:
                begin
                    div_req_reg.num   <= mul_p[NUM_W-1:0];
                    div_req_reg.den   <= {cfg.knee_width, 16'd0} - DEN_W'(cfg.knee_width);
                    state_reg         <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        xl_reg    <= div_quot;
                        state_reg <= S_REL1;
                    end
                end
                // Finish the slope above the knee and form the first release product
                S_REL1:
                begin
                    if (scale_reg)
                    begin
                        xl_reg <= sc_q[LVL_W-1:0];
                    end
                    acc_reg   <= mul_p[34:0];
                    state_reg <= S_REL2;
                end
                // Release stage, held up by the new reduction
                S_REL2:
                begin
                    rel_lvl_reg <= (sm_val > {1'b0, xl_reg}) ? sm_val[LVL_W-1:0] : xl_reg;
                    state_reg   <= S_ATK1;
                end
                S_ATK1:
                begin
                    acc_reg   <= mul_p[34:0];
                    state_reg <= S_ATK2;
                end
                S_ATK2:
                begin
                    atk_lvl_reg <= sm_val[LVL_W-1:0];
                    state_reg   <= S_GLOG;
                end
                S_GLOG:
                begin
                    glog_reg  <= glog_sum[31:11];
                    g_reg     <= 32'h8000_0000;
                    cnt_reg   <= 4'd0;
                    state_reg <= S_POW;
                end
                // Apply one root per fraction bit, most significant first
                S_POW:
                begin
                    if (glog_reg[~cnt_reg])
                    begin
                        g_reg <= pow_sum[63:32];
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_GSH;
                    end
                end
                S_GSH:
                begin
                    g_reg     <= g_reg >> glog_reg[20:16];
                    state_reg <= S_KMUL;
                end
                S_KMUL:
                begin
                    k_reg     <= k_sum[47:16];
                    state_reg <= S_OMUL;
                end
                // Scale, saturate and load the output word once it is free
                S_OMUL:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_sample_reg <= neg_reg ? SAMPLE_BITS'(39'd0 - o_sat)
                                                  : SAMPLE_BITS'(o_sat);
                        gain_red_reg   <= gr_sum[18:3];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_sample     = out_sample_reg;
    assign gain_reduction = gain_red_reg;
    assign div_req        = div_req_reg;

endmodule

// ----- design/soft_knee_audio_compressor_core.sv -----
// Top level of the soft-knee audio compressor
// Accept to valid output word runs through the shared 32x32 multiplier (2 to 11 normalize
// steps, 16 log squarings, 16 root products) and, inside the soft knee, the knee divide.
// A new sample is taken only once the output word of the last one is loaded, also while
// that word waits. Reset clears the detector levels and loads register defaults.
module soft_knee_audio_compressor_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [skac_pkg::IDX_W-1:0]       cfg_addr,
    input  logic [skac_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [skac_pkg::SAMPLE_BITS-1:0] sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [skac_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic [15:0]                      gain_reduction
);
    import skac_pkg::*;

    skac_cfg_t        cfg;
    skac_div_req_t    div_req;
    logic             div_done;
    logic [QUOT_W-1:0] div_quot;

    // Register file
    skac_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Curve divider
    skac_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer and shared multiplier
    skac_engine u_eng (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_sample     (out_sample),
        .gain_reduction (gain_reduction),
        .div_req        (div_req),
        .div_done       (div_done),
        .div_quot       (div_quot)
    );

endmodule

// ----- design/skac_checker.sv -----
// Port-level checks of the compressor, bound to the top level
module skac_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [skac_pkg::SAMPLE_BITS-1:0] out_sample,
    input logic [15:0]                      gain_reduction
);
    import skac_pkg::*;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
                                    && $stable(gain_reduction))
        else $error("output word changed while stalled");

    // Busy right after a sample is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accept");

    // A fresh result returns the block to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result without return to idle");

    // Reduction stays inside its range
    a_gr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain_reduction <= 16'd40960)
        else $error("gain reduction out of range");

endmodule

bind soft_knee_audio_compressor_core skac_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .gain_reduction (gain_reduction)
);

// ----- tb/soft_knee_audio_compressor_checker.sv -----
// Checker for the soft-knee compressor: tracks config, predicts each output word and compares
`timescale 1ns / 100ps

module soft_knee_audio_compressor_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [skac_pkg::IDX_W-1:0]       cfg_addr,
    input  logic [skac_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [skac_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [skac_pkg::SAMPLE_BITS-1:0] out_sample,
    input  logic [15:0]                      gain_reduction,
    output int                               failures,
    output int                               pending
);
    import skac_pkg::*;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_sample;
        logic [15:0]            gain_reduction;
    } comp_word_t;

    comp_word_t       expected_words[$];
    longint unsigned  gain_roots[16];

    // Mirrored register file and detector levels
    longint           thr_level;
    longint unsigned  knee, inv_ratio, atk_coef, rel_coef, makeup;
    longint unsigned  rel_level, atk_level;

    function automatic longint unsigned int_sqrt(longint unsigned x_in);
        longint unsigned x, r, b;
        x = x_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    initial
    begin
        gain_roots[0] = int_sqrt(64'd1 << 63);
        for (int k = 1; k < 16; k++)
            gain_roots[k] = int_sqrt(gain_roots[k-1] << 32);
    end

    function automatic longint unsigned one_pole(longint unsigned coef, longint unsigned old,
                                                 longint unsigned x);
        return (coef * old + (64'd65536 - coef) * x + 64'd32768) >> 16;
    endfunction

    // Run one sample through the level, curve, detector and gain stages
    function automatic comp_word_t compress_sample(logic [SAMPLE_BITS-1:0] raw);
        logic            neg;
        longint unsigned mag, v, lg, diff, c, xl, y1, yl, glog, g, k, o, half;
        longint          xg, d, e;
        int              p;
        comp_word_t      w;
        half = 64'd1 << (SAMPLE_BITS - 1);
        neg  = raw[SAMPLE_BITS-1];
        mag  = neg ? (64'd1 << SAMPLE_BITS) - raw : raw;
        if (mag == 0)
            xg = -40960;
        else
        begin
            p = 0;
            while (p < 63 && (mag >> (p + 1)) != 0)
                p++;
            v  = mag << (31 - p);
            lg = longint'(p) << 16;
            for (int i = 15; i >= 0; i--)
            begin
                v = (v * v) >> 31;
                if (v >= (64'd1 << 32))
                begin
                    lg = lg | (64'd1 << i);
                    v  = v >> 1;
                end
            end
            diff = (longint'(SAMPLE_BITS - 1) << 16) - lg;
            xg   = -longint'((diff * 64'd394566 + (64'd1 << 23)) >> 24);
        end
        d = xg - thr_level;
        c = 64'd65535 - inv_ratio;
        // Hard knee when the width is zero, else three regions
        if (knee == 0)
            xl = (d > 0) ? (64'd8 * c * longint'(d)) / 64'd65535 : 0;
        else
        begin
            e = 2 * d + longint'(knee);
            if (e < 0)
                xl = 0;
            else if (e <= 2 * longint'(knee))
                xl = (c * longint'(e) * longint'(e)) / (knee * 64'd65535);
            else
                xl = (64'd8 * c * longint'(d)) / 64'd65535;
        end
        // Release with hold-up, then attack
        y1 = one_pole(rel_coef, rel_level, xl);
        if (y1 < xl)
            y1 = xl;
        y1 = y1 & 64'h3FFFF;
        yl = one_pole(atk_coef, atk_level, y1) & 64'h3FFFF;
        rel_level = y1;
        atk_level = yl;
        // Log attenuation back to linear gain
        glog = (yl * 64'd10885 + 64'd1024) >> 11;
        g = 64'd1 << 31;
        for (int i = 0; i < 16; i++)
            if ((glog >> (15 - i)) & 64'd1)
                g = (g * gain_roots[i] + (64'd1 << 31)) >> 32;
        g = ((glog >> 16) >= 32) ? 0 : (g >> (glog >> 16));
        k = (g * makeup + 64'd32768) >> 16;
        o = (mag * k + (64'd1 << 24)) >> 25;
        if (neg)
        begin
            if (o > half)
                o = half;
            w.out_sample = SAMPLE_BITS'((64'd1 << SAMPLE_BITS) - o);
        end
        else
        begin
            if (o > half - 1)
                o = half - 1;
            w.out_sample = SAMPLE_BITS'(o);
        end
        w.gain_reduction = 16'((yl + 4) >> 3);
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        failures++;
    endtask

    initial
        failures = 0;

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        comp_word_t want;
        if (!rst_n)
        begin
            thr_level = 0;
            knee      = 0;
            inv_ratio = 65535;
            atk_coef  = 0;
            rel_coef  = 0;
            makeup    = 1024;
            rel_level = 0;
            atk_level = 0;
            expected_words.delete();
        end
        else
        begin
            // Track register writes
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_THRESHOLD: thr_level = longint'(signed'(cfg_wdata[14:0]));
                    REG_KNEE:      knee      = cfg_wdata[13:0];
                    REG_INV_RATIO: inv_ratio = cfg_wdata;
                    REG_ATTACK:    atk_coef  = cfg_wdata;
                    REG_RELEASE:   rel_coef  = cfg_wdata;
                    REG_MAKEUP:    makeup    = cfg_wdata;
                    default: ;
                endcase
            end
            // Predict each accepted input word
            if (in_valid && in_ready)
                expected_words.push_back(compress_sample(sample));
            // Compare each accepted output word with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected output word", out_sample, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (out_sample !== want.out_sample)
                        report_mismatch("out_sample", signed'(out_sample),
                                        signed'(want.out_sample));
                    if (gain_reduction !== want.gain_reduction)
                        report_mismatch("gain_reduction", gain_reduction,
                                        want.gain_reduction);
                end
            end
        end
    end

endmodule

// ----- tb/soft_knee_audio_compressor_core_test.sv -----
// Top of the compressor testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module soft_knee_audio_compressor_core_test;
    import skac_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 1400;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [IDX_W-1:0]        cfg_addr;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    in_valid;
    logic                    in_ready;
    logic [SAMPLE_BITS-1:0]  sample;
    logic                    out_valid;
    logic                    out_ready;
    logic [SAMPLE_BITS-1:0]  out_sample;
    logic [15:0]             gain_reduction;
    int                      failures;
    int                      pending;
    int                      cycle_count;
    int                      burst_left;

    soft_knee_audio_compressor_core dut (.*);

    soft_knee_audio_compressor_checker u_checker (.*);

    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // Abort on a hung run
    initial
        cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stalls: switch between four out_ready modes
    always @(negedge clk)
    begin
        case ((cycle_count / 337) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ((cycle_count % 11) < 4);
            default: out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Drive one word in bursts with random gaps, hold until accepted
    task automatic send_word(logic [SAMPLE_BITS-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        sample   = s;
        #1;
        while (!in_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        burst_left--;
    endtask

    // Drain the block, then load all six registers
    task automatic load_config(int thr, int knee, int ratio, int atk, int rel, int mk);
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (80) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = REG_THRESHOLD; cfg_wdata = CFG_W'(thr);
        @(negedge clk);
        cfg_addr = REG_KNEE;      cfg_wdata = CFG_W'(knee);
        @(negedge clk);
        cfg_addr = REG_INV_RATIO; cfg_wdata = CFG_W'(ratio);
        @(negedge clk);
        cfg_addr = REG_ATTACK;    cfg_wdata = CFG_W'(atk);
        @(negedge clk);
        cfg_addr = REG_RELEASE;   cfg_wdata = CFG_W'(rel);
        @(negedge clk);
        cfg_addr = REG_MAKEUP;    cfg_wdata = CFG_W'(mk);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [SAMPLE_BITS-1:0] s;
        int bits;
        case ($urandom_range(0, 9))
            0: s = '0;
            1, 2, 3: s = SAMPLE_BITS'($urandom);
            4, 5:
            begin
                bits = $urandom_range(1, SAMPLE_BITS - 1);
                s = SAMPLE_BITS'($urandom)
                    & ((SAMPLE_BITS'(1) << bits) - SAMPLE_BITS'(1));
                if ($urandom_range(0, 1))
                    s = -s;
            end
            6: s = SAMPLE_BITS'($urandom_range(0, 255)) ^ {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            7: s = SAMPLE_BITS'($urandom_range(0, 255)) | {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            8: s = $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                        : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            default: s = SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
        endcase
        return s;
    endfunction

    initial
    begin
        int thr, knee;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = REG_THRESHOLD;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        sample     = '0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: zero, extremes and small values
        send_word('0);
        send_word(24'h7FFFFF);
        send_word(24'h800000);
        send_word(24'h000001);
        send_word(24'hFFFFFF);
        send_word(24'h400000);

        // Hard knee, strong ratio, fast detector
        load_config(-6144, 0, 0, 0, 0, 65535);
        send_word(24'h7FFFFF);
        send_word(24'h800000);
        send_word(24'h123456);
        send_word('0);
        send_word(24'hC00000);
        send_word(24'h000100);

        // Widest soft knee, lowest threshold, slowest detector
        load_config(-15360, 12288, 16384, 65535, 65535, 0);
        send_word(24'h7FFFFF);
        send_word(24'h800000);
        send_word(24'h000010);
        send_word(24'h080000);
        send_word('0);

        // Soft knee near full scale, mid poles, unity makeup
        load_config(0, 3000, 32768, 40000, 60000, 1024);
        send_word(24'h7FFFFF);
        send_word(24'h700000);
        send_word(24'h900000);
        send_word(24'h7FFF00);
        send_word('0);

        // Random phases with random settings
        for (int ph = 0; ph < 7; ph++)
        begin
            thr  = -$urandom_range(0, 15360);
            knee = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12288);
            load_config(thr, knee, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
            for (int n = 0; n < RANDOM_WORDS / 7; n++)
            begin
                // Hold off once until every prediction has been matched
                if (ph == 3 && n == 100)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    wait (pending == 0);
                end
                send_word(random_sample());
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
